### rtl/tchm_pkg.sv
// ============================================================================
// tchm_pkg
// Shared types and constants for the corner hit-or-miss block: beat formats,
// configuration register indexes, probe kinds, result code weights and the
// command and status groups between the controller and the datapath.
// ============================================================================
package tchm_pkg;

    // Configuration port
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int ARM_FIELD_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_SIZE     = 2'd2;

    // Register values after reset (clamped to the parameters where used)
    localparam int RST_FRAME_WIDTH  = 256;
    localparam int RST_FRAME_HEIGHT = 256;
    localparam int RST_ARM_SIZE     = 1;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_ARM    = 8;

    // Window offsets: sized for the largest arm the 4-bit arm field holds (3*15 wide window)
    localparam int OFS_W = 8;

    // Operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Corner code weights
    localparam logic [7:0] CODE_DOWN_RIGHT = 8'd10;
    localparam logic [7:0] CODE_DOWN_LEFT  = 8'd20;
    localparam logic [7:0] CODE_UP_RIGHT   = 8'd40;
    localparam logic [7:0] CODE_UP_LEFT    = 8'd70;

    localparam int CORNER_COUNT = 4;

    // Probe kinds
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_CORNER = 3'd0;
    localparam t_kind KIND_UP     = 3'd1;
    localparam t_kind KIND_DOWN   = 3'd2;
    localparam t_kind KIND_LEFT   = 3'd3;
    localparam t_kind KIND_RIGHT  = 3'd4;

    // Beat formats
    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] corner_code;
        logic       last_pixel;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic                    load;
        logic                    start;
        logic                    probe;
        t_kind                   kind;
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic                    finish;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             full;
        logic             busy;
        logic             out_free;
        logic [OFS_W-2:0] centre;
        logic [OFS_W-2:0] far_len;
    } t_ctrl_status;

endpackage

### rtl/tchm_datapath.sv
// ============================================================================
// tchm_datapath
// Configuration registers, frame store, load and drain position counters,
// frame min/max, the probe pipeline (coordinate, address, store read, test)
// and the output register.
// ============================================================================
module tchm_datapath #(
    parameter int MAX_WIDTH  = tchm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tchm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_ARM    = tchm_pkg::DEF_MAX_ARM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tchm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tchm_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic [7:0]                     i_pixel,
    input  tchm_pkg::t_ctrl_cmd            i_cmd,
    output tchm_pkg::t_ctrl_status         o_status,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output tchm_pkg::t_out_item            o_out_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int ARMW  = $clog2(MAX_ARM + 1);
    localparam int KW    = $clog2(3 * MAX_ARM + 1);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW    = $clog2(MAXD + 64) + 1;
    localparam int RST_W = (MAX_WIDTH < tchm_pkg::RST_FRAME_WIDTH) ?
                           MAX_WIDTH : tchm_pkg::RST_FRAME_WIDTH;
    localparam int RST_H = (MAX_HEIGHT < tchm_pkg::RST_FRAME_HEIGHT) ?
                           MAX_HEIGHT : tchm_pkg::RST_FRAME_HEIGHT;

    // Configuration and frame bookkeeping
    logic [WW-1:0]   r_width;
    logic [HW-1:0]   r_height;
    logic [ARMW-1:0] r_arm;
    logic [AW-1:0]   r_load_addr;
    logic [XW-1:0]   r_load_x;
    logic [HW-1:0]   r_load_y;
    logic [XW-1:0]   r_drain_x;
    logic [YW-1:0]   r_drain_y;
    logic [7:0]      r_min;
    logic [7:0]      r_max;

    // Probe pipeline
    logic                  r_p1_valid, r_p2_valid, r_p3_valid;
    logic                  r_p1_inb, r_p2_inb, r_p3_inb;
    tchm_pkg::t_kind       r_p1_kind, r_p2_kind, r_p3_kind;
    logic [XW-1:0]         r_p1_x, r_p2_x;
    logic [YW-1:0]         r_p1_y;
    logic [AW-1:0]         r_p2_prod;
    logic [7:0]            r_rd_data;
    logic                  r_corner_ok, r_up_ok, r_down_ok, r_left_ok, r_right_ok;
    logic                  r_out_valid;
    tchm_pkg::t_out_item   r_out_data;

    logic [WW-1:0]   n_width;
    logic [HW-1:0]   n_height;
    logic [ARMW-1:0] n_arm;
    logic            cfg_hit;
    logic            restart;
    logic            full;
    logic            load_row_end;
    logic            drain_row_end;
    logic            drain_last;
    logic [KW-1:0]   win_k;
    logic [KW-1:0]   win_c;
    logic [KW-1:0]   win_far;
    logic signed [PW-1:0] xs, ys, w_s, h_s;
    logic            inb;
    logic [AW-1:0]   rd_addr;
    logic [8:0]      diff2;
    logic [8:0]      span;
    logic            fg;
    logic            hit;
    logic [7:0]      code;

    // Clamp register writes into their usable ranges
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_width  = WW'(1);
            n_height = HW'(1);
        end else begin
            n_width  = (int'(i_cfg_wr_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(i_cfg_wr_data);
            n_height = (int'(i_cfg_wr_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_wr_data);
        end
        if (i_cfg_wr_data[tchm_pkg::ARM_FIELD_W-1:0] == '0) begin
            n_arm = ARMW'(1);
        end else if (int'(i_cfg_wr_data[tchm_pkg::ARM_FIELD_W-1:0]) > MAX_ARM) begin
            n_arm = ARMW'(MAX_ARM);
        end else begin
            n_arm = ARMW'(i_cfg_wr_data[tchm_pkg::ARM_FIELD_W-1:0]);
        end
    end

    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == tchm_pkg::CFG_FRAME_WIDTH ||
                                     i_cfg_index == tchm_pkg::CFG_FRAME_HEIGHT ||
                                     i_cfg_index == tchm_pkg::CFG_ARM_SIZE);

    // Frame position flags
    assign full          = (r_load_y == r_height);
    assign load_row_end  = (WW'(r_load_x) == r_width - WW'(1));
    assign drain_row_end = (WW'(r_drain_x) == r_width - WW'(1));
    assign drain_last    = drain_row_end && (HW'(r_drain_y) == r_height - HW'(1));
    assign restart       = cfg_hit || (i_cmd.finish && drain_last);

    // Window geometry: side k = 3*arm, centre k/2, far arm k-1-centre
    assign win_k   = KW'(r_arm) + KW'({r_arm, 1'b0});
    assign win_c   = win_k >> 1;
    assign win_far = win_k - KW'(1) - win_c;

    // Probe coordinate and frame bounds
    assign xs  = $signed(PW'(r_drain_x)) + PW'(i_cmd.dx);
    assign ys  = $signed(PW'(r_drain_y)) + PW'(i_cmd.dy);
    assign w_s = $signed(PW'(r_width));
    assign h_s = $signed(PW'(r_height));
    assign inb = !xs[PW-1] && !ys[PW-1] && (xs < w_s) && (ys < h_s);

    // Store address from the registered row product
    assign rd_addr = r_p2_prod + AW'(r_p2_x);

    // Binarize the read pixel against the frame range
    assign diff2 = {r_rd_data - r_min, 1'b0};
    assign span  = {1'b0, r_max - r_min};
    assign fg    = (r_max > r_min) && (r_rd_data >= r_min) && (diff2 > span);
    assign hit   = r_p3_inb && ((r_p3_kind == tchm_pkg::KIND_CORNER) ? !fg : fg);

    // Sum the matched arm pairs
    always_comb begin
        code = 8'd0;
        if (r_corner_ok) begin
            if (r_down_ok && r_right_ok) code = code + tchm_pkg::CODE_DOWN_RIGHT;
            if (r_down_ok && r_left_ok)  code = code + tchm_pkg::CODE_DOWN_LEFT;
            if (r_up_ok && r_right_ok)   code = code + tchm_pkg::CODE_UP_RIGHT;
            if (r_up_ok && r_left_ok)    code = code + tchm_pkg::CODE_UP_LEFT;
        end
    end

    // Control state: configuration, counters, min/max, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(RST_W);
            r_height    <= HW'(RST_H);
            r_arm       <= ARMW'(tchm_pkg::RST_ARM_SIZE);
            r_load_addr <= '0;
            r_load_x    <= '0;
            r_load_y    <= '0;
            r_drain_x   <= '0;
            r_drain_y   <= '0;
            r_min       <= 8'hFF;
            r_max       <= 8'h00;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.probe;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;

            // Output register: load on finish, drop when taken
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    tchm_pkg::CFG_FRAME_WIDTH:  r_width  <= n_width;
                    tchm_pkg::CFG_FRAME_HEIGHT: r_height <= n_height;
                    tchm_pkg::CFG_ARM_SIZE:     r_arm    <= n_arm;
                    default: ;
                endcase
            end

            if (restart) begin
                r_load_addr <= '0;
                r_load_x    <= '0;
                r_load_y    <= '0;
                r_drain_x   <= '0;
                r_drain_y   <= '0;
                r_min       <= 8'hFF;
                r_max       <= 8'h00;
            end else begin
                // Advance the load position in raster order
                if (i_cmd.load) begin
                    r_load_addr <= r_load_addr + AW'(1);
                    if (load_row_end) begin
                        r_load_x <= '0;
                        r_load_y <= r_load_y + HW'(1);
                    end else begin
                        r_load_x <= r_load_x + XW'(1);
                    end
                    if (i_pixel < r_min) r_min <= i_pixel;
                    if (i_pixel > r_max) r_max <= i_pixel;
                end
                // Advance the drain position
                if (i_cmd.finish) begin
                    if (drain_row_end) begin
                        r_drain_x <= '0;
                        r_drain_y <= r_drain_y + YW'(1);
                    end else begin
                        r_drain_x <= r_drain_x + XW'(1);
                    end
                end
            end
        end
    end

    // Probe pipeline payload and test flags
    always_ff @(posedge i_clk) begin
        r_p1_inb  <= inb;
        r_p1_kind <= i_cmd.kind;
        r_p1_x    <= xs[XW-1:0];
        r_p1_y    <= ys[YW-1:0];

        r_p2_inb  <= r_p1_inb;
        r_p2_kind <= r_p1_kind;
        r_p2_x    <= r_p1_x;
        r_p2_prod <= AW'(r_p1_y) * AW'(r_width);

        r_p3_inb  <= r_p2_inb;
        r_p3_kind <= r_p2_kind;

        if (i_cmd.start) begin
            r_corner_ok <= 1'b1;
            r_up_ok     <= 1'b1;
            r_down_ok   <= 1'b1;
            r_left_ok   <= 1'b1;
            r_right_ok  <= 1'b1;
        end else if (r_p3_valid && !hit) begin
            case (r_p3_kind)
                tchm_pkg::KIND_CORNER: r_corner_ok <= 1'b0;
                tchm_pkg::KIND_UP:     r_up_ok     <= 1'b0;
                tchm_pkg::KIND_DOWN:   r_down_ok   <= 1'b0;
                tchm_pkg::KIND_LEFT:   r_left_ok   <= 1'b0;
                tchm_pkg::KIND_RIGHT:  r_right_ok  <= 1'b0;
                default: ;
            endcase
        end

        if (i_cmd.finish) begin
            r_out_data.corner_code <= code;
            r_out_data.last_pixel  <= drain_last;
        end
    end

    // Frame store: one write port for loads, one registered read port for probes
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_load_addr] <= i_pixel;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_status.full     = full;
    assign o_status.busy     = r_p1_valid || r_p2_valid || r_p3_valid;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.centre   = (tchm_pkg::OFS_W-1)'(win_c);
    assign o_status.far_len  = (tchm_pkg::OFS_W-1)'(win_far);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_finish_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || !i_out_stall))
        else $error("result written over an unaccepted beat");

    a_load_not_during_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !(r_p1_valid || r_p2_valid || r_p3_valid || i_cmd.probe))
        else $error("frame store written while probes are in flight");

    a_finish_on_full_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish || i_cmd.probe) |-> full)
        else $error("drain work on an incomplete frame");

    a_positions_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HW'(r_drain_y) < r_height) && (r_load_y <= r_height))
        else $error("load or drain position left the frame");

endmodule

### rtl/tchm_ctrl.sv
// ============================================================================
// tchm_ctrl
// Controller: takes input beats, issues loads, and for a drain steps through
// the four window corners and the up, down, left and right arms one probe per
// cycle, waits for the probe pipeline to empty and hands the result over.
// ============================================================================
module tchm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_operation,
    output logic                   o_in_stall,
    input  tchm_pkg::t_ctrl_status i_status,
    output tchm_pkg::t_ctrl_cmd    o_cmd
);

    localparam int SW = tchm_pkg::OFS_W - 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORNER = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_LEFT   = 3'd4;
    localparam logic [2:0] S_RIGHT  = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_step, n_step;

    logic signed [tchm_pkg::OFS_W-1:0] pos_step, neg_step;
    logic signed [tchm_pkg::OFS_W-1:0] pos_far, neg_c;
    logic                              last_corner;

    assign pos_step    = $signed({1'b0, r_step});
    assign neg_step    = -$signed({1'b0, r_step});
    assign pos_far     = $signed({1'b0, i_status.far_len});
    assign neg_c       = -$signed({1'b0, i_status.centre});
    assign last_corner = (r_step == SW'(tchm_pkg::CORNER_COUNT - 1));

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.kind   = tchm_pkg::KIND_CORNER;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == tchm_pkg::OP_LOAD) begin
                        o_cmd.load = !i_status.full;
                    end else if (i_status.full) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_CORNER;
                        n_step      = '0;
                    end
                end
            end
            S_CORNER: begin
                o_cmd.probe = 1'b1;
                o_cmd.kind  = tchm_pkg::KIND_CORNER;
                o_cmd.dx    = r_step[0] ? pos_far : neg_c;
                o_cmd.dy    = r_step[1] ? pos_far : neg_c;
                if (last_corner) begin
                    n_state = S_UP;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_UP: begin
                o_cmd.probe = 1'b1;
                o_cmd.kind  = tchm_pkg::KIND_UP;
                o_cmd.dy    = neg_step;
                if (r_step == i_status.centre) begin
                    n_state = S_DOWN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_DOWN: begin
                o_cmd.probe = 1'b1;
                o_cmd.kind  = tchm_pkg::KIND_DOWN;
                o_cmd.dy    = pos_step;
                if (r_step == i_status.far_len) begin
                    n_state = S_LEFT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_LEFT: begin
                o_cmd.probe = 1'b1;
                o_cmd.kind  = tchm_pkg::KIND_LEFT;
                o_cmd.dx    = neg_step;
                if (r_step == i_status.centre) begin
                    n_state = S_RIGHT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_RIGHT: begin
                o_cmd.probe = 1'b1;
                o_cmd.kind  = tchm_pkg::KIND_RIGHT;
                o_cmd.dx    = pos_step;
                if (r_step == i_status.far_len) begin
                    n_state = S_FLUSH;
                    n_step  = '0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_FLUSH: begin
                if (!i_status.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### rtl/table_corner_hit_or_miss.sv
// ============================================================================
// table_corner_hit_or_miss
// Hit-or-miss corner detector over one grey frame held in an on-chip store.
// ============================================================================
// Input channel (i_in_valid / o_in_stall / i_in_data): a load beat stores the
// next pixel of the frame in raster order and updates the frame min and max;
// loads may follow each other every cycle. Loads into
// a full frame are dropped. A drain beat, once the frame is complete, makes
// one result beat on the output channel (o_out_valid / i_out_stall /
// o_out_data) with the corner code of the next pixel; drains into an
// incomplete frame are dropped. A drain walks the four window corners and the
// four arms through the frame store, one read per cycle: 6*arm_size+6 probes,
// then waits for the probe pipeline to empty and hands the result over; input
// is stalled throughout the drain. The result sits in an output register;
// while it waits the block goes on taking input, and only the next result
// waits for it to be taken. After the final pixel, or any register write, the
// frame restarts. Reset restarts the frame and sets width 256, height 256,
// arm size 1; the store contents stay undefined.
// ============================================================================
module table_corner_hit_or_miss #(
    parameter int MAX_WIDTH  = tchm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tchm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_ARM    = tchm_pkg::DEF_MAX_ARM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tchm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tchm_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tchm_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tchm_pkg::t_out_item            o_out_data
);

    tchm_pkg::t_ctrl_cmd    cmd;
    tchm_pkg::t_ctrl_status status;

    // Sequence loads and drain probes
    tchm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Frame store, counters and probe pipeline
    tchm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_ARM    (MAX_ARM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel       (i_in_data.pixel_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

### tb/sv/table_corner_hit_or_miss_test.sv
// ============================================================================
// table_corner_hit_or_miss_test
// Self-checking bench for the corner hit-or-miss block. Frames are loaded in
// raster order and then drained; a predictor inside the bench keeps its own
// frame copy, min/max and settings, and works out the corner code and the
// last-pixel flag of every drained pixel. Results are checked in order.
// The sender idles and the receiver stalls at random; one long receiver hold-off makes
// the block back up and stall its input.
// ============================================================================
module table_corner_hit_or_miss_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = tchm_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H         = tchm_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_ARM_SIZE  = tchm_pkg::DEF_MAX_ARM;
    localparam int SETTLE_CYCLES = 6 * tchm_pkg::DEF_MAX_ARM + 12 + 40;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int AREA_CAP      = 600;
    localparam int HOLDOFF_AFTER = 100;
    localparam int HOLDOFF_LEN   = 600;
    localparam int PRINT_CAP     = 100;
    // plus sign on a 3x3 frame, first pixel in the top bit
    localparam bit [8:0] PLUS_SHAPE = 9'b010_111_010;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_e;
    typedef enum {FILL_NOISE, FILL_FLAT, FILL_GRID} fill_kind_e;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [tchm_pkg::CFG_IDX_W-1:0] i_cfg_index   = tchm_pkg::CFG_FRAME_WIDTH;
    logic [tchm_pkg::CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_stall;
    tchm_pkg::t_in_item             i_in_data     = '0;
    logic                           o_out_valid;
    logic                           i_out_stall   = 1'b0;
    tchm_pkg::t_out_item            o_out_data;

    table_corner_hit_or_miss dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    // Predictor state: frame copy, counters, min/max and raw register values
    logic [7:0] pixel_mem [MAX_W*MAX_H];
    int         pixels_loaded;
    int         pixels_drained;
    logic [7:0] frame_min;
    logic [7:0] frame_max;
    logic [8:0] reg_width;
    logic [8:0] reg_height;
    logic [3:0] reg_arm;

    tchm_pkg::t_in_item   beats_to_send [$];
    tchm_pkg::t_out_item  codes_due [$];
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         useful_items   = 0;
    int         cycle_count    = 0;
    bit         in_taken       = 1'b0;

    // Sender burst state and receiver stall state
    int          burst_left   = 1;
    int          gap_left     = 0;
    stall_kind_e stall_mode   = STALL_NONE;
    int          pattern_left = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        pixels_loaded  = 0;
        pixels_drained = 0;
        frame_min      = 8'd255;
        frame_max      = 8'd0;
    endfunction

    function automatic void apply_register(logic [tchm_pkg::CFG_IDX_W-1:0] idx,
                                           logic [tchm_pkg::CFG_W-1:0] data);
        case (idx)
            tchm_pkg::CFG_FRAME_WIDTH: reg_width = data[8:0];
            tchm_pkg::CFG_FRAME_HEIGHT: reg_height = data[8:0];
            tchm_pkg::CFG_ARM_SIZE: reg_arm = data[tchm_pkg::ARM_FIELD_W-1:0];
            default: return;
        endcase
        restart_frame();
    endfunction

    // In frame and of the wanted class; off-frame positions never match
    function automatic bit pixel_matches(int x, int y, int w, int h, bit want_fg);
        int p;
        int lo;
        int hi;
        bit is_fg;
        if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
        p     = int'(pixel_mem[y*w + x]);
        lo    = int'(frame_min);
        hi    = int'(frame_max);
        is_fg = (hi > lo) && (p >= lo) && (2 * (p - lo) > (hi - lo));
        return is_fg == want_fg;
    endfunction

    // Centre plus len steps along (dx,dy) all foreground
    function automatic bit arm_clear(int x, int y, int dx, int dy, int len, int w, int h);
        for (int s = 0; s <= len; s++)
            if (!pixel_matches(x + dx*s, y + dy*s, w, h, 1'b1)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] corner_code_at(int x, int y);
        int w;
        int h;
        int k;
        int c;
        int reach;
        bit up_ok;
        bit down_ok;
        bit left_ok;
        bit right_ok;
        logic [7:0] code;
        w     = clamp_dim(int'(reg_width), MAX_W);
        h     = clamp_dim(int'(reg_height), MAX_H);
        k     = 3 * clamp_dim(int'(reg_arm), MAX_ARM_SIZE);
        c     = k / 2;
        reach = k - 1 - c;
        code  = 8'd0;
        if (!(pixel_matches(x - c, y - c, w, h, 1'b0) &&
              pixel_matches(x + reach, y - c, w, h, 1'b0) &&
              pixel_matches(x - c, y + reach, w, h, 1'b0) &&
              pixel_matches(x + reach, y + reach, w, h, 1'b0)))
            return code;
        up_ok    = arm_clear(x, y, 0, -1, c, w, h);
        down_ok  = arm_clear(x, y, 0, 1, reach, w, h);
        left_ok  = arm_clear(x, y, -1, 0, c, w, h);
        right_ok = arm_clear(x, y, 1, 0, reach, w, h);
        if (down_ok && right_ok) code += tchm_pkg::CODE_DOWN_RIGHT;
        if (down_ok && left_ok) code += tchm_pkg::CODE_DOWN_LEFT;
        if (up_ok && right_ok) code += tchm_pkg::CODE_UP_RIGHT;
        if (up_ok && left_ok) code += tchm_pkg::CODE_UP_LEFT;
        return code;
    endfunction

    // Advance the predictor by one accepted input beat
    function automatic void take_beat(tchm_pkg::t_in_item b);
        int w;
        int h;
        int total;
        tchm_pkg::t_out_item r;
        w     = clamp_dim(int'(reg_width), MAX_W);
        h     = clamp_dim(int'(reg_height), MAX_H);
        total = w * h;
        if (b.operation == tchm_pkg::OP_LOAD) begin
            if (pixels_loaded >= total) return;
            pixel_mem[pixels_loaded] = b.pixel_value;
            pixels_loaded++;
            if (b.pixel_value < frame_min) frame_min = b.pixel_value;
            if (b.pixel_value > frame_max) frame_max = b.pixel_value;
            return;
        end
        if (pixels_loaded < total || pixels_drained >= total) return;
        r.corner_code = corner_code_at(pixels_drained % w, pixels_drained / w);
        r.last_pixel  = (pixels_drained == total - 1);
        pixels_drained++;
        codes_due.push_back(r);
        if (pixels_drained >= total) restart_frame();
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t: result %0d: %s: got %0d, want %0d",
                     $time, results_seen, what, got, want);
    endtask

    // Monitor: check result beats, then feed accepted input beats to the predictor
    always @(posedge i_clk) begin
        tchm_pkg::t_out_item want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (codes_due.size() == 0) begin
                flag_mismatch("result beat with nothing due",
                              int'(o_out_data.corner_code), -1);
            end else begin
                want = codes_due.pop_front();
                if (o_out_data.corner_code !== want.corner_code)
                    flag_mismatch("corner_code", int'(o_out_data.corner_code),
                                  int'(want.corner_code));
                if (o_out_data.last_pixel !== want.last_pixel)
                    flag_mismatch("last_pixel", int'(o_out_data.last_pixel),
                                  int'(want.last_pixel));
            end
        end
        if (in_taken) take_beat(i_in_data);
    end

    // Driver: send queued beats in bursts with random gaps
    always @(negedge i_clk) begin
        logic               next_valid;
        tchm_pkg::t_in_item next_beat;
        next_valid = i_in_valid;
        next_beat  = i_in_data;
        if (!i_in_valid || in_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (beats_to_send.size() > 0) begin
                next_beat  = beats_to_send.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_data  <= next_beat;
    end

    // Receiver: stall on a changing pattern, with one long hold-off
    always @(negedge i_clk) begin
        logic next_stall;
        if (pattern_left == 0) begin
            stall_mode   = stall_kind_e'($urandom_range(0, 3));
            pattern_left = $urandom_range(50, 300);
        end else begin
            pattern_left--;
        end
        if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_done = 1'b1;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            next_stall = 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE: next_stall = 1'b0;
                STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
                default: next_stall = !i_out_stall;
            endcase
        end
        i_out_stall <= next_stall;
    end

    task automatic push_beat(logic op, logic [7:0] value);
        tchm_pkg::t_in_item b;
        b.operation   = op;
        b.pixel_value = value;
        beats_to_send.push_back(b);
    endtask

    // Write the masked registers back to back, then drop the enable
    task automatic write_settings(logic [8:0] w, logic [8:0] h, logic [8:0] a,
                                  logic [2:0] mask);
        logic [tchm_pkg::CFG_IDX_W-1:0] idx;
        logic [tchm_pkg::CFG_W-1:0]     data;
        for (int i = 0; i < 3; i++) begin
            if (mask[i]) begin
                idx  = (i == 0) ? tchm_pkg::CFG_FRAME_WIDTH :
                       (i == 1) ? tchm_pkg::CFG_FRAME_HEIGHT : tchm_pkg::CFG_ARM_SIZE;
                data = (i == 0) ? w : (i == 1) ? h : a;
                @(negedge i_clk);
                i_cfg_wr_en   <= 1'b1;
                i_cfg_index   <= idx;
                i_cfg_wr_data <= data;
                apply_register(idx, data);
            end
        end
        if (mask != 3'b000) begin
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b0;
        end
    endtask

    // Wait until every beat is sent and every result taken, then let the block settle
    task automatic wait_idle();
        while (beats_to_send.size() > 0 || i_in_valid || codes_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One frame at the current settings: loads, then drains, with stray beats mixed in
    task automatic queue_frame(fill_kind_e fill, bit abort);
        int w;
        int total;
        int cut;
        int flat_value;
        bit row_line [MAX_H];
        bit col_line [MAX_W];
        logic [7:0] v;
        w     = clamp_dim(int'(reg_width), MAX_W);
        total = w * clamp_dim(int'(reg_height), MAX_H);
        foreach (row_line[i]) row_line[i] = ($urandom_range(0, 2) == 0);
        foreach (col_line[i]) col_line[i] = ($urandom_range(0, 2) == 0);
        flat_value = $urandom_range(0, 255);
        cut = abort ? $urandom_range(0, total - 1) : total;
        // drains into an incomplete frame are dropped
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                push_beat(tchm_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(tchm_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
            case (fill)
                FILL_NOISE: v = 8'($urandom_range(0, 255));
                FILL_FLAT: v = 8'(flat_value);
                default: v = (row_line[i / w] || col_line[i % w]) ?
                             8'($urandom_range(170, 255)) : 8'($urandom_range(0, 90));
            endcase
            push_beat(tchm_pkg::OP_LOAD, v);
        end
        if (abort) begin
            useful_items += cut;
            return;
        end
        // loads into a full frame are dropped
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                push_beat(tchm_pkg::OP_LOAD, 8'($urandom_range(0, 255)));
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(tchm_pkg::OP_LOAD, 8'($urandom_range(0, 255)));
            push_beat(tchm_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
        end
        // a drain after the final pixel hits a fresh, empty frame
        if ($urandom_range(0, 3) == 0)
            push_beat(tchm_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
        useful_items += 2 * total;
    endtask

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Sequencer: reset, directed frames, extreme settings, random frames, end
    initial begin
        logic [8:0] w_raw;
        logic [8:0] h_raw;
        logic [8:0] arm_raw;
        logic [2:0] mask;
        int         cw;
        int         new_w;
        int         new_h;
        int         pick;
        bit         abort;
        bit         frame_open;
        fill_kind_e fill;

        reg_width  = 9'(tchm_pkg::RST_FRAME_WIDTH);
        reg_height = 9'(tchm_pkg::RST_FRAME_HEIGHT);
        reg_arm    = 4'(tchm_pkg::RST_ARM_SIZE);
        restart_frame();
        frame_open = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drain straight after reset: frame empty, dropped
        push_beat(tchm_pkg::OP_DRAIN, 8'hFF);
        wait_idle();

        // Plus sign on a 3x3 frame: full code at the centre, off-frame edges elsewhere
        write_settings(9'd3, 9'd3, 9'd1, 3'b111);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) push_beat(tchm_pkg::OP_DRAIN, 8'h00);
            push_beat(tchm_pkg::OP_LOAD, PLUS_SHAPE[8-i] ? 8'd255 : 8'd0);
        end
        push_beat(tchm_pkg::OP_LOAD, 8'd200);
        repeat (9) push_beat(tchm_pkg::OP_DRAIN, 8'h00);
        push_beat(tchm_pkg::OP_DRAIN, 8'h5A);
        wait_idle();

        // Extreme and out-of-range settings
        write_settings(9'd511, 9'd1, 9'd0, 3'b111);
        queue_frame(FILL_NOISE, 1'b0);
        wait_idle();
        write_settings(9'd0, 9'd0, 9'd3, 3'b111);
        queue_frame(FILL_FLAT, 1'b0);
        wait_idle();
        write_settings(9'd7, 9'd6, 9'h1F2, 3'b111);
        queue_frame(FILL_GRID, 1'b0);
        wait_idle();

        // Random frames, mostly small
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) w_raw = 9'd0;
            else if (pick == 1) w_raw = 9'($urandom_range(256, 511));
            else if (pick == 2) w_raw = 9'($urandom_range(13, 40));
            else w_raw = 9'($urandom_range(1, 12));
            cw   = clamp_dim(int'(w_raw), MAX_W);
            pick = $urandom_range(0, 15);
            if (pick == 0) h_raw = 9'd0;
            else if (pick == 1 && cw <= 2) h_raw = 9'($urandom_range(256, 511));
            else h_raw = 9'($urandom_range(1, (cw > 40) ? 2 : 12));
            pick = $urandom_range(0, 9);
            if (pick == 0) arm_raw = 9'd0;
            else if (pick == 1) arm_raw = 9'($urandom_range(8, 15));
            else arm_raw = 9'($urandom_range(1, 3));
            if ($urandom_range(0, 4) == 0) arm_raw[8:4] = 5'($urandom_range(0, 31));

            mask = 3'($urandom_range(1, 7));
            if (!frame_open && $urandom_range(0, 3) == 0) mask = 3'b000;
            new_w = clamp_dim(int'(mask[0] ? w_raw : reg_width), MAX_W);
            new_h = clamp_dim(int'(mask[1] ? h_raw : reg_height), MAX_H);
            if (new_w * new_h > AREA_CAP) mask = mask | 3'b011;
            write_settings(w_raw, h_raw, arm_raw, mask);

            pick  = $urandom_range(0, 19);
            fill  = (pick < 12) ? FILL_GRID : (pick < 17) ? FILL_NOISE : FILL_FLAT;
            abort = ($urandom_range(0, 9) == 0);
            queue_frame(fill, abort);
            frame_open = abort;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/tchm_pkg.sv
rtl/tchm_datapath.sv
rtl/tchm_ctrl.sv
rtl/table_corner_hit_or_miss.sv
tb/sv/table_corner_hit_or_miss_test.sv
